// File: rtl/tfn_pkg.sv
// ---------------------------------------------------------------------------
// tfn_pkg: shared constants for the triangle face normal block
// Default coordinate and fraction widths and the fixed result word layout.
// ---------------------------------------------------------------------------
package tfn_pkg;

    // Default vertex coordinate width (signed Q12.12)
    localparam int COORD_BITS     = 24;
    // Default fraction bits of a normalised component
    localparam int UNIT_FRAC_BITS = 30;
    // Width of one result component
    localparam int OUT_BITS       = 50;
    // Result tdata: three components, padded to whole bytes
    localparam int OUT_TDATA_W    = ((3 * OUT_BITS + 7) / 8) * 8;

endpackage

// File: rtl/tfn_front.sv
// ---------------------------------------------------------------------------
// tfn_front: edges, cross product and sum of squares
// Six stages: edges, products, differences and magnitudes, split partial
// squares, whole squares, sum of the three squares.
// ---------------------------------------------------------------------------
module tfn_front #(
    parameter int CB = tfn_pkg::COORD_BITS,
    parameter int MW = 2 * (CB + 1),
    parameter int SW = 2 * MW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [9*CB-1:0] i_coord,
    input  logic            i_norm,
    output logic            o_valid,
    output logic [3*MW-1:0] o_mag,
    output logic [2:0]      o_sgn,
    output logic            o_norm,
    output logic [SW-1:0]   o_sum
);

    localparam int EW = CB + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;
    localparam int H  = (MW + 1) / 2;
    localparam int HW = MW - H;

    logic signed [CB-1:0] crd [9];
    logic [5:0]           r_v;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p  [6];
    logic [MW-1:0]        r_m3 [3];
    logic [MW-1:0]        r_m4 [3];
    logic [MW-1:0]        r_m5 [3];
    logic [MW-1:0]        r_m6 [3];
    logic [2:0]           r_s3, r_s4, r_s5, r_s6;
    logic [5:0]           r_nm;
    logic [2*H-1:0]       r_ll [3];
    logic [MW-1:0]        r_lh [3];
    logic [2*HW-1:0]      r_hh [3];
    logic [SW-1:0]        r_sq [3];
    logic [SW-1:0]        r_sum;

    logic signed [NW-1:0] nd [3];
    logic [NW-1:0]        na [3];

    // Unpack the nine coordinates, a first
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            crd[i] = i_coord[i*CB +: CB];
        end
    end

    // Form the three cross product components and their magnitudes
    always_comb begin
        nd[0] = NW'(r_p[0]) - NW'(r_p[1]);
        nd[1] = NW'(r_p[2]) - NW'(r_p[3]);
        nd[2] = NW'(r_p[4]) - NW'(r_p[5]);
        for (int k = 0; k < 3; k++) begin
            na[k] = nd[k][NW-1] ? NW'(-nd[k]) : NW'(nd[k]);
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Advance the word through the six stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm <= {r_nm[4:0], i_norm};
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= {crd[3+k][CB-1], crd[3+k]} - {crd[k][CB-1], crd[k]};
                r_e2[k] <= {crd[6+k][CB-1], crd[6+k]} - {crd[k][CB-1], crd[k]};
            end
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int k = 0; k < 3; k++) begin
                r_s3[k] <= nd[k][NW-1];
                r_m3[k] <= na[k][MW-1:0];
                r_ll[k] <= (2*H)'(r_m3[k][H-1:0]) * (2*H)'(r_m3[k][H-1:0]);
                r_lh[k] <= MW'(r_m3[k][H-1:0]) * MW'(r_m3[k][MW-1:H]);
                r_hh[k] <= (2*HW)'(r_m3[k][MW-1:H]) * (2*HW)'(r_m3[k][MW-1:H]);
                r_sq[k] <= (SW'(r_hh[k]) << (2 * H)) + (SW'(r_lh[k]) << (H + 1))
                         + SW'(r_ll[k]);
            end
            r_m4  <= r_m3;
            r_m5  <= r_m4;
            r_m6  <= r_m5;
            r_s4  <= r_s3;
            r_s5  <= r_s4;
            r_s6  <= r_s5;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_valid = r_v[5];
    assign o_mag   = {r_m6[2], r_m6[1], r_m6[0]};
    assign o_sgn   = r_s6;
    assign o_norm  = r_nm[5];
    assign o_sum   = r_sum;

endmodule

// File: rtl/tfn_sqrt_cell.sv
// ---------------------------------------------------------------------------
// tfn_sqrt_cell: one root bit of the integer square root
// Tries one bit of the root against the running remainder and hands the
// remainder, partial root and carried word to the next cell.
// ---------------------------------------------------------------------------
module tfn_sqrt_cell #(
    parameter int SW   = 100,
    parameter int STEP = 0,
    parameter int PW   = 154
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [SW-1:0] i_x,
    input  logic [SW-1:0] i_res,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [SW-1:0] o_x,
    output logic [SW-1:0] o_res,
    output logic [PW-1:0] o_pay
);

    localparam logic [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} << (SW - 2 - 2 * STEP);

    logic [SW-1:0] t;
    logic          ge;

    // Trial subtract of the current bit
    always_comb begin
        t  = i_res + ONE;
        ge = (i_x >= t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // Keep the bit where the remainder allows it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= ge ? i_x - t : i_x;
            o_res <= ge ? (i_res >> 1) + ONE : i_res >> 1;
            o_pay <= i_pay;
        end
    end

endmodule

// File: rtl/tfn_div_cell.sv
// ---------------------------------------------------------------------------
// tfn_div_cell: one quotient bit for the three components
// Restoring division step shared by x, y and z against the common length.
// ---------------------------------------------------------------------------
module tfn_div_cell #(
    parameter int MW    = 50,
    parameter int QW    = 31,
    parameter int PW    = 155,
    parameter int FIRST = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [3*(MW+1)-1:0] i_r,
    input  logic [3*QW-1:0]   i_q,
    input  logic [MW-1:0]     i_len,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [3*(MW+1)-1:0] o_r,
    output logic [3*QW-1:0]   o_q,
    output logic [MW-1:0]     o_len,
    output logic [PW-1:0]     o_pay
);

    logic [MW:0]     rr [3];
    logic [2:0]      ge;
    logic [3*(MW+1)-1:0] n_r;
    logic [3*QW-1:0] n_q;

    // Shift in the next numerator bit (zero), except in the first cell, and compare with the length
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rr[k] = (FIRST != 0) ? i_r[k*(MW+1) +: MW+1]
                                 : {i_r[k*(MW+1) +: MW], 1'b0};
            ge[k] = (rr[k] >= {1'b0, i_len});
            n_r[k*(MW+1) +: MW+1] = ge[k] ? rr[k] - {1'b0, i_len} : rr[k];
            n_q[k*QW +: QW]       = {i_q[k*QW +: QW-1], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r   <= n_r;
            o_q   <= n_q;
            o_len <= i_len;
            o_pay <= i_pay;
        end
    end

endmodule

// File: rtl/triangle_face_normal.sv
// ---------------------------------------------------------------------------
// triangle_face_normal: surface normal of a triangle
// Cross product of the edges b-a and c-a, optionally scaled to unit length.
// ---------------------------------------------------------------------------
// Input stream (s_axis): one word per triangle, nine signed coordinates in
// tdata and the normalise flag in tuser. Output stream (m_axis): the three
// components in tdata and the degenerate flag in tuser.
// Without normalise the exact cross product is returned; with it each
// component is scaled by 2^UNIT_FRAC_BITS over the floor square root of the
// squared length, truncated toward zero. A zero length gives zeros and sets
// degenerate.
// Throughput: one triangle per cycle while the receiver does not stall. A
// word passes through the six front stages, then the chain of square root
// cells (one root bit each) and divider cells (one quotient bit each), then
// the output register.
// All cells move together; when the receiver stalls with a word waiting in
// the output register, the whole chain holds and tready drops.
// Reset clears every valid bit; no word is in flight afterwards.
// ---------------------------------------------------------------------------
module triangle_face_normal #(
    parameter int COORD_BITS     = tfn_pkg::COORD_BITS,
    parameter int UNIT_FRAC_BITS = tfn_pkg::UNIT_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, then zero padding
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // normalize
    input  logic [0:0] i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // normal_x, normal_y, normal_z, then zero padding
    output logic [tfn_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // degenerate
    output logic [0:0] o_m_axis_tuser
);

    localparam int CB  = COORD_BITS;
    localparam int MW  = 2 * (CB + 1);
    localparam int SW  = 2 * MW;
    localparam int QW  = UNIT_FRAC_BITS + 1;
    localparam int SPW = 3 * MW + 4;
    localparam int DPW = 3 * MW + 5;
    localparam int OB  = tfn_pkg::OUT_BITS;

    logic en;

    logic            f_valid;
    logic [3*MW-1:0] f_mag;
    logic [2:0]      f_sgn;
    logic            f_norm;
    logic [SW-1:0]   f_sum;

    logic            sq_v   [MW+1];
    logic [SW-1:0]   sq_x   [MW+1];
    logic [SW-1:0]   sq_res [MW+1];
    logic [SPW-1:0]  sq_pay [MW+1];

    logic            dv_v   [QW+1];
    logic [3*(MW+1)-1:0] dv_r [QW+1];
    logic [3*QW-1:0] dv_q   [QW+1];
    logic [MW-1:0]   dv_len [QW+1];
    logic [DPW-1:0]  dv_pay [QW+1];

    logic [MW-1:0]   root;
    logic [3*(MW+1)-1:0] r_init;
    logic [DPW-1:0]  fin_pay;
    logic [2:0]      fin_sgn;
    logic            fin_norm;
    logic            fin_lz;
    logic [OB-1:0]   comp [3];

    logic                         r_ov;
    logic [tfn_pkg::OUT_TDATA_W-1:0] r_odata;
    logic                         r_odeg;

    // Whole chain advances while the output register is free or being taken
    assign en              = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;

    tfn_front #(.CB(CB), .MW(MW), .SW(SW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_coord (i_s_axis_tdata[9*CB-1:0]),
        .i_norm  (i_s_axis_tuser[0]),
        .o_valid (f_valid),
        .o_mag   (f_mag),
        .o_sgn   (f_sgn),
        .o_norm  (f_norm),
        .o_sum   (f_sum)
    );

    // Square root chain, most significant root bit first
    assign sq_v[0]   = f_valid;
    assign sq_x[0]   = f_sum;
    assign sq_res[0] = '0;
    assign sq_pay[0] = {f_norm, f_sgn, f_mag};

    for (genvar i = 0; i < MW; i++) begin : g_sqrt
        tfn_sqrt_cell #(.SW(SW), .STEP(i), .PW(SPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[i]),
            .i_x     (sq_x[i]),
            .i_res   (sq_res[i]),
            .i_pay   (sq_pay[i]),
            .o_valid (sq_v[i+1]),
            .o_x     (sq_x[i+1]),
            .o_res   (sq_res[i+1]),
            .o_pay   (sq_pay[i+1])
        );
    end

    // Load the dividers with the magnitudes and the length
    always_comb begin
        root = sq_res[MW][MW-1:0];
        for (int k = 0; k < 3; k++) begin
            r_init[k*(MW+1) +: MW+1] = {1'b0, sq_pay[MW][k*MW +: MW]};
        end
    end

    assign dv_v[0]   = sq_v[MW];
    assign dv_r[0]   = r_init;
    assign dv_q[0]   = '0;
    assign dv_len[0] = root;
    assign dv_pay[0] = {sq_pay[MW][SPW-1:3*MW], (root == '0), sq_pay[MW][3*MW-1:0]};

    for (genvar i = 0; i < QW; i++) begin : g_div
        tfn_div_cell #(.MW(MW), .QW(QW), .PW(DPW), .FIRST(i == 0)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[i]),
            .i_r     (dv_r[i]),
            .i_q     (dv_q[i]),
            .i_len   (dv_len[i]),
            .i_pay   (dv_pay[i]),
            .o_valid (dv_v[i+1]),
            .o_r     (dv_r[i+1]),
            .o_q     (dv_q[i+1]),
            .o_len   (dv_len[i+1]),
            .o_pay   (dv_pay[i+1])
        );
    end

    // Pick raw product, zero vector or signed quotient
    always_comb begin
        fin_pay  = dv_pay[QW];
        fin_norm = fin_pay[DPW-1];
        fin_sgn  = fin_pay[DPW-2:DPW-4];
        fin_lz   = fin_pay[3*MW];
        for (int k = 0; k < 3; k++) begin
            if (!fin_norm) begin
                comp[k] = fin_sgn[k] ? OB'(-OB'(fin_pay[k*MW +: MW]))
                                     : OB'(fin_pay[k*MW +: MW]);
            end else if (fin_lz) begin
                comp[k] = '0;
            end else begin
                comp[k] = fin_sgn[k] ? OB'(-OB'(dv_q[QW][k*QW +: QW]))
                                     : OB'(dv_q[QW][k*QW +: QW]);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata <= tfn_pkg::OUT_TDATA_W'({comp[2], comp[1], comp[0]});
            r_odeg  <= fin_norm && fin_lz;
        end
    end

    assign o_m_axis_tvalid   = r_ov;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_odeg;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("degenerate word carries a non-zero vector");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input held off without an output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output word present straight after reset");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking regression for triangle_face_normal
// Streams triangles through the block with random idling on both sides and a
// long receiver hold-off, predicts each normal (raw or unit) and compares
// every returned word field by field, in order.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CB      = tfn_pkg::COORD_BITS;
    localparam int UFB     = tfn_pkg::UNIT_FRAC_BITS;
    localparam int OB      = tfn_pkg::OUT_BITS;
    localparam int IN_W    = ((9*CB+7)/8)*8;
    localparam int OUT_W   = tfn_pkg::OUT_TDATA_W;
    localparam int LATENCY = 6 + 2*(CB+1) + UFB + 2;
    localparam int N_RAND  = 1100;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic [IN_W-1:0] coords;
        logic            normalize;
    } tri_word_t;

    typedef struct packed {
        logic [OB-1:0] nx;
        logic [OB-1:0] ny;
        logic [OB-1:0] nz;
        logic          degenerate;
    } normal_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;
    logic [0:0]        i_s_axis_tuser;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic [0:0]        o_m_axis_tuser;

    // Whether the word on offer was taken at the last rising edge
    logic              o_s_axis_tready_q = 1'b0;

    tri_word_t pending_tris[$];
    normal_t   expected_normals[$];
    int        errors = 0;
    int        cycles = 0;
    int        n_checked = 0;
    int        n_unit = 0;
    int        n_degen = 0;
    bit        stim_done = 0;
    bit        calm = 0;
    int        hold_off = 0;

    triangle_face_normal DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Clock: 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Floor square root of a 128-bit sum, one bit at a time
    function automatic logic [63:0] floor_root(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= s) r = t;
        end
        return r;
    endfunction

    // Scale one component to unit length, truncating toward zero
    function automatic logic [63:0] unit_scale(logic signed [63:0] c, logic [63:0] len);
        logic [127:0] m;
        logic [63:0]  q;
        m = (c < 0) ? 128'(-c) : 128'(c);
        q = 64'((m << UFB) / {64'd0, len});
        return (c < 0) ? -q : q;
    endfunction

    // Work out the normal that one triangle should give
    function automatic normal_t face_normal(tri_word_t w);
        logic signed [63:0] v[9];
        logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
        logic [127:0] s;
        logic [63:0]  len;
        normal_t r;
        for (int i = 0; i < 9; i++) v[i] = 64'(signed'(w.coords[i*CB +: CB]));
        e1x = v[3] - v[0]; e1y = v[4] - v[1]; e1z = v[5] - v[2];
        e2x = v[6] - v[0]; e2y = v[7] - v[1]; e2z = v[8] - v[2];
        cx = e1y*e2z - e1z*e2y;
        cy = e1z*e2x - e1x*e2z;
        cz = e1x*e2y - e1y*e2x;
        r.degenerate = 1'b0;
        if (w.normalize) begin
            s = 128'(cx < 0 ? -cx : cx) * 128'(cx < 0 ? -cx : cx)
              + 128'(cy < 0 ? -cy : cy) * 128'(cy < 0 ? -cy : cy)
              + 128'(cz < 0 ? -cz : cz) * 128'(cz < 0 ? -cz : cz);
            len = floor_root(s);
            if (len == 0) begin
                cx = 0; cy = 0; cz = 0;
                r.degenerate = 1'b1;
            end else begin
                cx = unit_scale(cx, len);
                cy = unit_scale(cy, len);
                cz = unit_scale(cz, len);
            end
        end
        r.nx = cx[OB-1:0];
        r.ny = cy[OB-1:0];
        r.nz = cz[OB-1:0];
        return r;
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(CB-1){1'b1}}};
            1:       return {1'b1, {(CB-1){1'b0}}};
            2:       return CB'($urandom_range(0, 64)) - CB'(32);
            3:       return CB'($urandom_range(0, 8191)) - CB'(4096);
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic queue_tri(logic [CB-1:0] c[9], logic nrm);
        tri_word_t w;
        w.coords = '0;
        for (int i = 0; i < 9; i++) w.coords[i*CB +: CB] = c[i];
        w.normalize = nrm;
        pending_tris.push_back(w);
    endtask

    // Fill the queue: directed corners first, then random triangles
    initial begin
        logic [CB-1:0] c[9];
        logic [CB-1:0] mx;
        logic [CB-1:0] mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        for (int n = 0; n < 2; n++) begin
            // all zero: degenerate when normalised
            foreach (c[i]) c[i] = '0;
            queue_tri(c, n);
            // unit right triangle in the xy plane
            c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
            queue_tri(c, n);
            // collinear points
            c = '{1, 1, 1, 2, 2, 2, 3, 3, 3};
            queue_tri(c, n);
            // extremes
            c = '{mn, mn, mn, mx, mx, mx, mx, mn, mx};
            queue_tri(c, n);
            c = '{mx, mx, mx, mn, mn, mn, mn, mx, mn};
            queue_tri(c, n);
            c = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
            queue_tri(c, n);
            foreach (c[i]) c[i] = '1;
            queue_tri(c, n);
            c = '{0, 0, 0, mx, 0, 0, 0, mn, 0};
            queue_tri(c, n);
            // tiny cross product: length just 1
            c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
            queue_tri(c, n);
            c = '{5, 5, 5, 5, 6, 5, 5, 5, 4};
            queue_tri(c, n);
        end
        for (int k = 0; k < N_RAND; k++) begin
            foreach (c[i]) c[i] = rand_coord();
            // occasionally repeat a vertex for a zero-area triangle
            if ($urandom_range(0, 19) == 0)
                for (int i = 0; i < 3; i++) c[3+i] = c[i];
            queue_tri(c, $urandom_range(0, 1));
        end
        stim_done = 1;
    end

    // Reset, quiet stretch and final report
    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && pending_tris.size() == 0 && !i_s_axis_tvalid
              && expected_normals.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d normals (%0d unit, %0d degenerate) with random idling",
                 n_checked, n_unit, n_degen);
        $display("and a long output stall that backed up the pipeline.");
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Cycle limit; calm stretch with no idling around cycles 900-1200
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        calm   <= (cycles >= 900 && cycles < 1200);
        if (cycles >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: offer the next word at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tuser  <= '0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready_q) begin
            if (pending_tris.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= pending_tris[0].coords;
                i_s_axis_tuser  <= pending_tris[0].normalize;
                expected_normals.push_back(face_normal(pending_tris[0]));
                if (pending_tris[0].normalize) n_unit <= n_unit + 1;
                void'(pending_tris.pop_front());
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Record whether the word on offer was taken at the last rising edge
    always @(posedge i_clk) o_s_axis_tready_q <= o_s_axis_tready;

    // Receiver readiness: random stalls, one long hold-off
    always @(negedge i_clk) begin
        if (cycles == 300) hold_off <= 400;
        else if (hold_off > 0) hold_off <= hold_off - 1;
        if (hold_off > 0 || cycles == 300)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
    end

    // Monitor: compare each returned word with the oldest prediction
    always @(posedge i_clk) begin
        normal_t got;
        normal_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.nx = o_m_axis_tdata[0 +: OB];
            got.ny = o_m_axis_tdata[OB +: OB];
            got.nz = o_m_axis_tdata[2*OB +: OB];
            got.degenerate = o_m_axis_tuser[0];
            if (expected_normals.size() == 0) begin
                $error("unexpected result word %h", o_m_axis_tdata);
                errors = errors + 1;
            end else begin
                want = expected_normals.pop_front();
                n_checked = n_checked + 1;
                if (want.degenerate) n_degen = n_degen + 1;
                if (got.nx !== want.nx) begin
                    $error("normal_x expected %h actual %h", want.nx, got.nx);
                    errors = errors + 1;
                end
                if (got.ny !== want.ny) begin
                    $error("normal_y expected %h actual %h", want.ny, got.ny);
                    errors = errors + 1;
                end
                if (got.nz !== want.nz) begin
                    $error("normal_z expected %h actual %h", want.nz, got.nz);
                    errors = errors + 1;
                end
                if (got.degenerate !== want.degenerate) begin
                    $error("degenerate expected %b actual %b",
                           want.degenerate, got.degenerate);
                    errors = errors + 1;
                end
            end
        end
    end

endmodule

// File: triangle_face_normal.f
rtl/tfn_pkg.sv
rtl/tfn_front.sv
rtl/tfn_sqrt_cell.sv
rtl/tfn_div_cell.sv
rtl/triangle_face_normal.sv
sim/testbench.sv
